FILE: rtl/assert_macros.svh
// assertion macros shared by the timer bank rtl
// expects signals named clk and rst in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// condition that must never hold outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

FILE: rtl/potb_pkg.sv
// shared types and constants for the per-owner timer bank
// no dependencies; used by potb_slot_ram and per_owner_timer_bank
package potb_pkg;

  localparam int OWNER_W  = 3;
  localparam int SLOT_W   = 4;
  localparam int PERIOD_W = 32;
  localparam int COUNT_W  = 32;
  localparam int STEP_W   = 10;

  localparam logic [STEP_W-1:0]   STEP_RESET = 10'd10;
  localparam logic [PERIOD_W-1:0] FREE_RUN   = '1;

  typedef enum logic [1:0] {
    OP_SET    = 2'd0,
    OP_READ   = 2'd1,
    OP_CANCEL = 2'd2,
    OP_TICK   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_ASSIGN    = 2'd0,
    KIND_COUNT     = 2'd1,
    KIND_EXPIRY    = 2'd2,
    KIND_IDLE_TICK = 2'd3
  } kind_t;

  // request word
  typedef struct packed {
    op_t                        op;
    logic [OWNER_W-1:0]         owner;
    logic [SLOT_W-1:0]          slot;
    logic signed [PERIOD_W-1:0] period;
  } req_t;

  // response word
  typedef struct packed {
    kind_t               kind;
    logic [OWNER_W-1:0]  which_owner;
    logic [SLOT_W-1:0]   which_slot;
    logic [COUNT_W-1:0]  count_value;
    logic                owner_active;
    logic                last;
  } rsp_t;

endpackage

FILE: rtl/per_owner_timer_bank.sv
// channel   words     valid      stall      accepted when
// req       req_t     req_valid  req_stall  req_valid && !req_stall
// rsp       rsp_t     rsp_valid  rsp_stall  rsp_valid && !rsp_stall
// cfg       step      cfg_wr_en  (none)     cfg_wr_en
//
// set, read and cancel pass through S_SET or S_ACCESS, then load the response register from S_EMIT.
// tick: an owner with no active mark is skipped; an active owner reads each of its SLOTS
// slots in S_TSCAN, then passes S_TDRAIN and reports each expiry in S_TEXP; S_TEND and
// S_EMIT close the tick. the single memory read port sets the per-slot pace.
// reset clears the busy bits and owner marks; no memory sweep.
// one word at a time; req_stall is high until the last response is queued.
//
// top level of the per-owner timer bank; depends on potb_pkg, potb_slot_ram
// and assert_macros.svh
module per_owner_timer_bank #(
  parameter int OWNERS = 4,
  parameter int SLOTS  = 12
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  potb_pkg::req_t              req_word,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output potb_pkg::rsp_t              rsp_word,
  input  logic                        cfg_wr_en,
  input  logic [potb_pkg::STEP_W-1:0] cfg_wr_data
);

  localparam int ENTRIES = OWNERS * SLOTS;
  localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OIDX_W  = (OWNERS > 1) ? $clog2(OWNERS) : 1;
  localparam int SIDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW      = potb_pkg::COUNT_W;
  localparam int PW      = potb_pkg::PERIOD_W;

  typedef enum logic [2:0] {
    S_IDLE, S_SET, S_ACCESS, S_TSCAN, S_TDRAIN, S_TEXP, S_TEND, S_EMIT
  } state_t;

  state_t                      state;
  potb_pkg::req_t              req;
  logic [potb_pkg::STEP_W-1:0] tick_step;
  logic [SLOTS-1:0]            busy [OWNERS];
  logic [OWNERS-1:0]           owner_busy;
  logic [OIDX_W-1:0]           scan_owner;
  logic [SIDX_W-1:0]           scan_slot;
  logic                        p2_valid;
  logic [ADDR_W-1:0]           p2_addr;
  logic [SIDX_W-1:0]           p2_slot;
  logic [SLOTS-1:0]            exp_mask;
  potb_pkg::rsp_t              pend;
  logic                        pend_valid;

  // memory port signals
  logic              cnt_we, per_we;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [CW-1:0]     cnt_wdata, cnt_rdata;
  logic [PW-1:0]     per_wdata, per_rdata;

  potb_slot_ram #(
    .DEPTH  (ENTRIES),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk       (clk),
    .cnt_we    (cnt_we),
    .per_we    (per_we),
    .wr_addr   (wr_addr),
    .cnt_wdata (cnt_wdata),
    .per_wdata (per_wdata),
    .rd_addr   (rd_addr),
    .cnt_rdata (cnt_rdata),
    .per_rdata (per_rdata)
  );

  logic out_load;
  assign out_load  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != S_IDLE);

  // incoming word decode, for the read issued at acceptance
  logic              in_owner_ok, in_slot_ok;
  logic [ADDR_W-1:0] in_addr;
  assign in_owner_ok = int'(req_word.owner) < OWNERS;
  assign in_slot_ok  = int'(req_word.slot) < SLOTS;
  assign in_addr = (in_owner_ok && in_slot_ok) ?
                   ADDR_W'(req_word.owner[OIDX_W-1:0]) * ADDR_W'(SLOTS) +
                   ADDR_W'(req_word.slot[SIDX_W-1:0]) : '0;

  // latched word decode
  logic              owner_ok, slot_ok;
  logic [OIDX_W-1:0] oidx;
  logic [SIDX_W-1:0] sidx;
  logic [SLOTS-1:0]  row, row_after, slot_bit;
  logic              owner_mark;
  assign owner_ok   = int'(req.owner) < OWNERS;
  assign slot_ok    = int'(req.slot) < SLOTS;
  assign oidx       = req.owner[OIDX_W-1:0];
  assign sidx       = req.slot[SIDX_W-1:0];
  assign row        = owner_ok ? busy[oidx] : '0;
  assign owner_mark = owner_ok ? owner_busy[oidx] : 1'b0;
  assign slot_bit   = slot_ok ? (SLOTS'(1) << sidx) : '0;
  assign row_after  = row & ~slot_bit;

  // lowest free slot of the requesting owner
  logic              free_found;
  logic [SIDX_W-1:0] free_idx;
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!row[i]) begin
        free_found = 1'b1;
        free_idx   = SIDX_W'(i);
      end
    end
  end

  // tick scan address and row
  logic [ADDR_W-1:0] scan_addr;
  logic [SLOTS-1:0]  scan_row;
  assign scan_addr = ADDR_W'(scan_owner) * ADDR_W'(SLOTS) + ADDR_W'(scan_slot);
  assign scan_row  = busy[scan_owner];

  // tick update: saturating add and expiry test on the returned entry
  logic [CW:0]   tick_sum;
  logic [CW-1:0] tick_sat;
  logic          tick_expire;
  assign tick_sum    = {1'b0, cnt_rdata} + (CW+1)'(tick_step);
  assign tick_sat    = tick_sum[CW] ? '1 : tick_sum[CW-1:0];
  assign tick_expire = (per_rdata != potb_pkg::FREE_RUN) &&
                       ($signed({1'b0, tick_sat}) >= $signed({per_rdata[PW-1], per_rdata}));

  // lowest pending expiry of the scanned owner
  logic [SIDX_W-1:0] exp_idx;
  always_comb begin
    exp_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (exp_mask[i]) begin
        exp_idx = SIDX_W'(i);
      end
    end
  end

  // read address: request fields at acceptance, scan position during a tick
  assign rd_addr = (state == S_IDLE) ? in_addr : scan_addr;

  // write port: set claims a slot, tick writes back a surviving count
  always_comb begin
    cnt_we    = 1'b0;
    per_we    = 1'b0;
    wr_addr   = p2_addr;
    cnt_wdata = tick_sat;
    per_wdata = req.period;
    if (state == S_SET) begin
      cnt_we    = owner_ok && free_found;
      per_we    = owner_ok && free_found;
      wr_addr   = ADDR_W'(oidx) * ADDR_W'(SLOTS) + ADDR_W'(free_idx);
      cnt_wdata = '0;
    end else if (p2_valid && !tick_expire) begin
      cnt_we = 1'b1;
    end
  end

  // response register loads from the emit state or from the held expiry
  logic rsp_load;
  assign rsp_load = out_load &&
                    ((state == S_EMIT) || (state == S_TEXP && (|exp_mask) && pend_valid));

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_step <= potb_pkg::STEP_RESET;
    end else if (cfg_wr_en) begin
      tick_step <= cfg_wr_data;
    end
  end

  // sequencer, slot state and response registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      owner_busy <= '0;
      for (int o = 0; o < OWNERS; o++) begin
        busy[o] <= '0;
      end
      scan_owner <= '0;
      scan_slot  <= '0;
      p2_valid   <= 1'b0;
      exp_mask   <= '0;
      pend_valid <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      p2_valid <= (state == S_TSCAN) && owner_busy[scan_owner] && scan_row[scan_slot];
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      // second tick stage: count comes back from memory
      if (p2_valid && tick_expire) begin
        busy[scan_owner][p2_slot] <= 1'b0;
        exp_mask[p2_slot]         <= 1'b1;
      end

      case (state)
        S_IDLE: begin
          if (req_valid) begin
            req <= req_word;
            case (req_word.op)
              potb_pkg::OP_SET:  state <= S_SET;
              potb_pkg::OP_TICK: begin
                scan_owner <= '0;
                scan_slot  <= '0;
                pend_valid <= 1'b0;
                state      <= S_TSCAN;
              end
              default:           state <= S_ACCESS;
            endcase
          end
        end

        // claim the lowest free slot
        S_SET: begin
          if (owner_ok) begin
            owner_busy[oidx] <= 1'b1;
            if (free_found) begin
              busy[oidx][free_idx] <= (req.period != '0);
            end
          end
          pend <= '{kind: potb_pkg::KIND_ASSIGN, which_owner: req.owner,
                    which_slot: (owner_ok && free_found) ?
                                potb_pkg::SLOT_W'(free_idx) : potb_pkg::SLOT_W'(SLOTS),
                    count_value: '0, owner_active: owner_ok, last: 1'b1};
          state <= S_EMIT;
        end

        // read or cancel, memory data now available
        S_ACCESS: begin
          if (req.op == potb_pkg::OP_CANCEL && owner_ok && slot_ok) begin
            busy[oidx][sidx] <= 1'b0;
            owner_busy[oidx] <= |row_after;
          end
          pend <= '{kind: potb_pkg::KIND_COUNT, which_owner: req.owner,
                    which_slot: req.slot,
                    count_value: (|(row & slot_bit)) ? cnt_rdata : '0,
                    owner_active: (req.op == potb_pkg::OP_CANCEL && owner_ok && slot_ok) ?
                                  |row_after : owner_mark,
                    last: 1'b1};
          state <= S_EMIT;
        end

        // first tick stage: issue a read for each slot of one active owner
        S_TSCAN: begin
          if (!owner_busy[scan_owner]) begin
            if (int'(scan_owner) == OWNERS - 1) begin
              state <= S_TEND;
            end else begin
              scan_owner <= scan_owner + 1'b1;
            end
          end else begin
            p2_addr  <= scan_addr;
            p2_slot  <= scan_slot;
            if (int'(scan_slot) == SLOTS - 1) begin
              state <= S_TDRAIN;
            end else begin
              scan_slot <= scan_slot + 1'b1;
            end
          end
        end

        // last slot of the owner finishes its write back
        S_TDRAIN: begin
          state <= S_TEXP;
        end

        // report the owner's expiries, holding one back for the last mark
        S_TEXP: begin
          owner_busy[scan_owner] <= |scan_row;
          if (|exp_mask) begin
            if (!pend_valid || out_load) begin
              if (pend_valid) begin
                rsp_word <= pend;
              end
              pend <= '{kind: potb_pkg::KIND_EXPIRY,
                        which_owner: potb_pkg::OWNER_W'(scan_owner),
                        which_slot: potb_pkg::SLOT_W'(exp_idx), count_value: '0,
                        owner_active: |scan_row, last: 1'b0};
              pend_valid        <= 1'b1;
              exp_mask[exp_idx] <= 1'b0;
            end
          end else if (int'(scan_owner) == OWNERS - 1) begin
            state <= S_TEND;
          end else begin
            scan_owner <= scan_owner + 1'b1;
            scan_slot  <= '0;
            state      <= S_TSCAN;
          end
        end

        // close the tick: mark the held expiry last, or report a quiet tick
        S_TEND: begin
          if (pend_valid) begin
            pend.last <= 1'b1;
          end else begin
            pend <= '{kind: potb_pkg::KIND_IDLE_TICK, which_owner: '0, which_slot: '0,
                      count_value: '0, owner_active: 1'b0, last: 1'b1};
          end
          pend_valid <= 1'b0;
          state      <= S_EMIT;
        end

        S_EMIT: begin
          if (out_load) begin
            rsp_word <= pend;
            state    <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // owners that still hold a busy slot
  logic [OWNERS-1:0] row_any;
  always_comb begin
    for (int o = 0; o < OWNERS; o++) begin
      row_any[o] = |busy[o];
    end
  end

`include "assert_macros.svh"

  `ASSERT_NEVER(a_busy_owner_marked, |(row_any & ~owner_busy), "busy slot under unmarked owner")
  `ASSERT_IMPL(a_p2_in_tick, p2_valid, (state == S_TSCAN || state == S_TDRAIN), "stray write back")
  `ASSERT_NEXT(a_emit_last, (state == S_EMIT && out_load), (rsp_valid && rsp_word.last), "final word not marked last")

endmodule

FILE: rtl/potb_slot_ram.sv
// slot store: count and period memories, one write and one read address per cycle
// read data registered; depends on potb_pkg
module potb_slot_ram #(
  parameter int DEPTH  = 48,
  parameter int ADDR_W = 6
) (
  input  logic                          clk,
  input  logic                          cnt_we,
  input  logic                          per_we,
  input  logic [ADDR_W-1:0]             wr_addr,
  input  logic [potb_pkg::COUNT_W-1:0]  cnt_wdata,
  input  logic [potb_pkg::PERIOD_W-1:0] per_wdata,
  input  logic [ADDR_W-1:0]             rd_addr,
  output logic [potb_pkg::COUNT_W-1:0]  cnt_rdata,
  output logic [potb_pkg::PERIOD_W-1:0] per_rdata
);

  logic [potb_pkg::COUNT_W-1:0]  cnt_mem [DEPTH];
  logic [potb_pkg::PERIOD_W-1:0] per_mem [DEPTH];

  // count memory
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[wr_addr] <= cnt_wdata;
    end
    cnt_rdata <= cnt_mem[rd_addr];
  end

  // period memory
  always_ff @(posedge clk) begin
    if (per_we) begin
      per_mem[wr_addr] <= per_wdata;
    end
    per_rdata <= per_mem[rd_addr];
  end

endmodule

FILE: tb/sv/testbench.sv
// self-checking bench for per_owner_timer_bank: a tracker class mirrors slots,
// periods and owner marks, and checks every response word in order
// depends on potb_pkg and the per_owner_timer_bank rtl
module testbench;

  localparam int NUM_OWNERS      = 4;
  localparam int NUM_SLOTS       = 12;
  localparam int ITEMS_PER_PHASE = 66;
  localparam int IDLE_LIMIT      = 4000;
  localparam int SETTLE_CYCLES   = 150;
  localparam int SHOWN_MISMATCH  = 10;

  // mirror of the bank state and the queue of response words still due
  class timer_bank_tracker;
    logic [potb_pkg::COUNT_W-1:0]  count_mem [NUM_OWNERS*NUM_SLOTS];
    logic [potb_pkg::PERIOD_W-1:0] period_mem [NUM_OWNERS*NUM_SLOTS];
    logic                          owner_mark [NUM_OWNERS];
    logic [potb_pkg::STEP_W-1:0]   step;
    potb_pkg::rsp_t                due_words [$];
    int                            mismatches;

    function new();
      foreach (count_mem[i]) begin
        count_mem[i]  = '0;
        period_mem[i] = '0;
      end
      foreach (owner_mark[o]) owner_mark[o] = 1'b0;
      step       = potb_pkg::STEP_RESET;
      mismatches = 0;
    endfunction

    function int pending();
      return due_words.size();
    endfunction

    function bit has_busy(int o);
      for (int s = 0; s < NUM_SLOTS; s++)
        if (period_mem[o*NUM_SLOTS+s] != '0) return 1'b1;
      return 1'b0;
    endfunction

    function potb_pkg::rsp_t rsp_of(potb_pkg::kind_t k, logic [potb_pkg::OWNER_W-1:0] o,
                                    logic [potb_pkg::SLOT_W-1:0] s,
                                    logic [potb_pkg::COUNT_W-1:0] c, logic a);
      potb_pkg::rsp_t w;
      w.kind         = k;
      w.which_owner  = o;
      w.which_slot   = s;
      w.count_value  = c;
      w.owner_active = a;
      w.last         = 1'b0;
      return w;
    endfunction

    // update the mirror for one accepted request word and queue its responses
    function void apply_request(potb_pkg::req_t r);
      potb_pkg::rsp_t               words [$];
      int                           base;
      int                           x;
      logic [potb_pkg::COUNT_W:0]   sum;
      logic [potb_pkg::COUNT_W-1:0] c;
      logic                         a;
      case (r.op)
        potb_pkg::OP_TICK: begin
          for (int o = 0; o < NUM_OWNERS; o++) begin
            if (owner_mark[o]) begin
              base = words.size();
              for (int s = 0; s < NUM_SLOTS; s++) begin
                x = o*NUM_SLOTS + s;
                if (period_mem[x] != '0) begin
                  // saturating add, then expiry test against the signed period
                  sum = {1'b0, count_mem[x]} + step;
                  count_mem[x] = sum[potb_pkg::COUNT_W] ? '1 : sum[potb_pkg::COUNT_W-1:0];
                  if (period_mem[x] != potb_pkg::FREE_RUN &&
                      longint'(count_mem[x]) >= longint'($signed(period_mem[x]))) begin
                    count_mem[x]  = '0;
                    period_mem[x] = '0;
                    words.push_back(rsp_of(potb_pkg::KIND_EXPIRY, potb_pkg::OWNER_W'(o),
                                           potb_pkg::SLOT_W'(s), '0, 1'b0));
                  end
                end
              end
              owner_mark[o] = has_busy(o);
              for (int k = base; k < words.size(); k++) words[k].owner_active = owner_mark[o];
            end
          end
          if (words.size() == 0)
            words.push_back(rsp_of(potb_pkg::KIND_IDLE_TICK, '0, '0, '0, 1'b0));
        end
        potb_pkg::OP_SET: begin
          if (r.owner >= NUM_OWNERS) begin
            words.push_back(rsp_of(potb_pkg::KIND_ASSIGN, r.owner,
                                   potb_pkg::SLOT_W'(NUM_SLOTS), '0, 1'b0));
          end else begin
            // lowest free slot, or NUM_SLOTS when the owner is full
            x = NUM_SLOTS;
            for (int s = NUM_SLOTS-1; s >= 0; s--)
              if (period_mem[int'(r.owner)*NUM_SLOTS+s] == '0) x = s;
            if (x < NUM_SLOTS) begin
              count_mem[int'(r.owner)*NUM_SLOTS+x]  = '0;
              period_mem[int'(r.owner)*NUM_SLOTS+x] = r.period;
            end
            owner_mark[r.owner] = 1'b1;
            words.push_back(rsp_of(potb_pkg::KIND_ASSIGN, r.owner,
                                   potb_pkg::SLOT_W'(x), '0, 1'b1));
          end
        end
        default: begin
          // read and cancel
          c = '0;
          a = 1'b0;
          if (r.owner < NUM_OWNERS) begin
            if (r.slot < NUM_SLOTS) begin
              x = int'(r.owner)*NUM_SLOTS + int'(r.slot);
              c = count_mem[x];
              if (r.op == potb_pkg::OP_CANCEL) begin
                count_mem[x]  = '0;
                period_mem[x] = '0;
                if (!has_busy(r.owner)) owner_mark[r.owner] = 1'b0;
              end
            end
            a = owner_mark[r.owner];
          end
          words.push_back(rsp_of(potb_pkg::KIND_COUNT, r.owner, r.slot, c, a));
        end
      endcase
      words[words.size()-1].last = 1'b1;
      foreach (words[k]) due_words.push_back(words[k]);
    endfunction

    function void report(string why, potb_pkg::rsp_t want, potb_pkg::rsp_t got);
      mismatches++;
      if (mismatches <= SHOWN_MISMATCH)
        $display({"mismatch %0d (%s): expected kind %0d owner %0d slot %0d count %0d ",
                  "active %0b last %0b, got kind %0d owner %0d slot %0d count %0d ",
                  "active %0b last %0b"}, mismatches, why,
                 want.kind, want.which_owner, want.which_slot, want.count_value,
                 want.owner_active, want.last,
                 got.kind, got.which_owner, got.which_slot, got.count_value,
                 got.owner_active, got.last);
    endfunction

    // compare one accepted response word with the oldest one due
    function void check_response(potb_pkg::rsp_t got);
      potb_pkg::rsp_t want;
      if (due_words.size() == 0) begin
        report("nothing due", '0, got);
        return;
      end
      want = due_words.pop_front();
      if (got.kind !== want.kind || got.which_owner !== want.which_owner ||
          got.which_slot !== want.which_slot || got.count_value !== want.count_value ||
          got.owner_active !== want.owner_active || got.last !== want.last)
        report("field differs", want, got);
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst;
  logic                        req_valid;
  logic                        req_stall;
  potb_pkg::req_t              req_word;
  logic                        rsp_valid;
  logic                        rsp_stall;
  potb_pkg::rsp_t              rsp_word;
  logic                        cfg_wr_en;
  logic [potb_pkg::STEP_W-1:0] cfg_wr_data;

  bit                gaps_on = 1'b1;
  int                stall_left = 0;
  int                idle_cycles = 0;
  timer_bank_tracker tracker;

  per_owner_timer_bank #(
    .OWNERS (NUM_OWNERS),
    .SLOTS  (NUM_SLOTS)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req_word    (req_word),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp_word    (rsp_word),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // clock, period 4
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // response side stalls in random bursts
  always @(posedge clk) begin
    if (rst) begin
      stall_left = 0;
      rsp_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_stall <= 1'b1;
    end else if (gaps_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 9);
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  // handshake monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && !rsp_stall) tracker.check_response(rsp_word);
      if (req_valid && !req_stall) tracker.apply_request(req_word);
      if (cfg_wr_en) tracker.step = cfg_wr_data;
      if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall) || cfg_wr_en)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  function automatic potb_pkg::req_t req_of(potb_pkg::op_t op, int owner, int slot,
                                            logic [potb_pkg::PERIOD_W-1:0] period);
    potb_pkg::req_t r;
    r.op     = op;
    r.owner  = potb_pkg::OWNER_W'(owner);
    r.slot   = potb_pkg::SLOT_W'(slot);
    r.period = period;
    return r;
  endfunction

  // present one request word, with an occasional gap before it
  task automatic send_req(input potb_pkg::req_t r);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_word  <= r;
    do @(posedge clk); while (req_stall);
  endtask

  // hold off requests until every due response has arrived
  task automatic wait_drained();
    req_valid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
  endtask

  initial begin
    potb_pkg::req_t              r;
    int                          pick;
    int                          span;
    logic [potb_pkg::STEP_W-1:0] cur_step;
    logic [potb_pkg::STEP_W-1:0] steps [6];

    tracker = new();
    rst         <= 1'b1;
    req_valid   <= 1'b0;
    req_word    <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    cur_step = potb_pkg::STEP_RESET;

    // directed: idle tick and out-of-range owners
    send_req(req_of(potb_pkg::OP_TICK, 0, 0, '0));
    send_req(req_of(potb_pkg::OP_READ, 0, 0, '0));
    send_req(req_of(potb_pkg::OP_SET, 7, 15, 32'd5));
    send_req(req_of(potb_pkg::OP_READ, 5, 3, '0));
    send_req(req_of(potb_pkg::OP_CANCEL, 6, 15, '0));
    // zero period marks the owner but leaves the slot free
    send_req(req_of(potb_pkg::OP_SET, 1, 0, '0));
    // periods below -1, the largest period and the shortest
    send_req(req_of(potb_pkg::OP_SET, 2, 0, 32'hffff_fffe));
    send_req(req_of(potb_pkg::OP_SET, 2, 0, 32'h8000_0000));
    send_req(req_of(potb_pkg::OP_SET, 3, 0, 32'h7fff_ffff));
    send_req(req_of(potb_pkg::OP_SET, 3, 0, 32'd1));
    // fill owner 0 with free-running slots, then one set too many
    repeat (NUM_SLOTS) send_req(req_of(potb_pkg::OP_SET, 0, 0, potb_pkg::FREE_RUN));
    send_req(req_of(potb_pkg::OP_SET, 0, 0, 32'd40));
    send_req(req_of(potb_pkg::OP_TICK, 4, 9, 32'hdead_beef));
    send_req(req_of(potb_pkg::OP_READ, 0, 15, '0));
    send_req(req_of(potb_pkg::OP_CANCEL, 0, 5, '0));
    send_req(req_of(potb_pkg::OP_READ, 0, 5, '0));

    // random phases, one tick step each; the last phase runs without gaps
    steps = '{10'd1, 10'd1000, 10'd0, 10'd1023,
              potb_pkg::STEP_W'($urandom_range(2, 999)), potb_pkg::STEP_RESET};
    foreach (steps[p]) begin
      if (p == 5) gaps_on = 1'b0;
      wait_drained();
      cfg_wr_en   <= 1'b1;
      cfg_wr_data <= steps[p];
      cur_step     = steps[p];
      @(posedge clk);
      cfg_wr_en <= 1'b0;
      span = 6 * ((cur_step == 0) ? 10 : int'(cur_step));
      repeat (ITEMS_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        r.op = (pick < 35) ? potb_pkg::OP_SET : (pick < 50) ? potb_pkg::OP_READ :
               (pick < 72) ? potb_pkg::OP_CANCEL : potb_pkg::OP_TICK;
        r.owner = ($urandom_range(0, 9) == 0) ? potb_pkg::OWNER_W'($urandom_range(4, 7))
                                               : potb_pkg::OWNER_W'($urandom_range(0, 3));
        // low slots fill first, so most reads and cancels aim there
        pick = $urandom_range(0, 9);
        r.slot = (pick == 0) ? potb_pkg::SLOT_W'($urandom_range(12, 15)) :
                 (pick < 7)  ? potb_pkg::SLOT_W'($urandom_range(0, 5)) :
                               potb_pkg::SLOT_W'($urandom_range(0, 11));
        pick = $urandom_range(0, 99);
        if (pick < 60)      r.period = $urandom_range(1, span);
        else if (pick < 70) r.period = potb_pkg::FREE_RUN;
        else if (pick < 76) r.period = '0;
        else if (pick < 84) r.period = {1'b1, 31'($urandom)};
        else if (pick < 92) r.period = $urandom;
        else if (pick < 96) r.period = 32'h7fff_ffff;
        else                r.period = 32'd1;
        send_req(r);
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
